// ===== src/jsu_pkg.sv =====
// Package for the JSON string unescape core.
// Holds phase and status codes, the job record passed from front to back,
// character constants and the hex and UTF-8 helper functions. No dependencies.
package jsu_pkg;

  // Default width of the saturating decoded-length counter.
  localparam int LENGTH_WIDTH_DEF = 16;
  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH_DEF  = 4;
  // Width of the decoded_length output field.
  localparam int OUT_LEN_W        = 16;

  // Characters the parser looks for.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BSLASH    = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CTRL_BS      = 8'h08;
  localparam logic [7:0] CTRL_FF      = 8'h0C;
  localparam logic [7:0] CTRL_LF      = 8'h0A;
  localparam logic [7:0] CTRL_CR      = 8'h0D;
  localparam logic [7:0] CTRL_TAB     = 8'h09;

  // Top six bits of a high and a low surrogate.
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef enum logic [2:0] {
    PH_NORMAL     = 3'd0,
    PH_ESC        = 3'd1,
    PH_HEX_FIRST  = 3'd2,
    PH_WANT_BS    = 3'd3,
    PH_WANT_U     = 3'd4,
    PH_HEX_SECOND = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_HEX  = 3'd1,
    ST_BAD_SURR = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_NO_QUOTE = 3'd4,
    ST_BAD_CHAR = 3'd5
  } status_t;

  // One job: up to four output bytes, or a single done beat.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // number of beats minus one
    logic            is_done;
    status_t         status;
  } job_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  // A job that emits a single byte.
  function automatic job_t one_byte(input logic [7:0] b);
    job_t j;
    j = '0;
    j.bytes[0] = b;
    j.status   = ST_OK;
    return j;
  endfunction

  // A done beat with the given status.
  function automatic job_t done_job(input status_t s);
    job_t j;
    j = '0;
    j.is_done = 1'b1;
    j.status  = s;
    return j;
  endfunction

  // UTF-8 encoding of a code point into one to four bytes.
  function automatic job_t utf8_encode(input logic [20:0] cp);
    job_t j;
    j = '0;
    j.status = ST_OK;
    if (cp <= 21'h7F) begin
      j.bytes[0] = cp[7:0];
      j.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

endpackage

// ===== src/jsu_in_if.sv =====
// Input channel of the JSON string unescape core: one raw string byte per beat.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== src/jsu_out_if.sv =====
// Result channel of the JSON string unescape core: one decoded byte or done per beat.
// Depends on nothing.
interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_done;
  logic [2:0]  status;
  logic [15:0] decoded_length;
  logic        last;

  modport source (output valid, output out_byte, output is_done, output status,
                  output decoded_length, output last, input ready);
  modport sink   (input valid, input out_byte, input is_done, input status,
                  input decoded_length, input last, output ready);
endinterface

// ===== src/jsu_front.sv =====
// Front end: accepts raw bytes, tracks escape and surrogate parsing, and
// pushes one job per byte that yields results. Depends on jsu_pkg, jsu_in_if.
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  jsu_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output jsu_pkg::job_t q_job
);
  import jsu_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] hex_acc_r, hex_acc_nxt;   // first three digits of the value
  logic [9:0]  high_r, high_nxt;          // high surrogate minus 0xD800
  logic        accept;
  logic        emit;
  job_t        job;
  logic [7:0]  c;
  logic [4:0]  hv;
  logic [15:0] full_val;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.in_byte;
  assign hv          = hex_value(c);
  assign full_val    = {hex_acc_r, hv[3:0]};

  // Parser state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_NORMAL;
      hex_cnt_r <= 2'd0;
      hex_acc_r <= 12'd0;
      high_r    <= 10'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_acc_r <= hex_acc_nxt;
      high_r    <= high_nxt;
    end
  end

  // Next state and the job for the current byte. A done clears all state.
  always_comb begin
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_acc_nxt = hex_acc_r;
    high_nxt    = high_r;
    emit        = 1'b0;
    job         = '0;

    unique case (phase_r)
      PH_ESC: begin
        phase_nxt = PH_NORMAL;
        emit      = 1'b1;
        unique case (c)
          CH_QUOTE:  job = one_byte(CH_QUOTE);
          CH_BSLASH: job = one_byte(CH_BSLASH);
          CH_SLASH:  job = one_byte(CH_SLASH);
          CH_B:      job = one_byte(CTRL_BS);
          CH_F:      job = one_byte(CTRL_FF);
          CH_N:      job = one_byte(CTRL_LF);
          CH_R:      job = one_byte(CTRL_CR);
          CH_T:      job = one_byte(CTRL_TAB);
          CH_U: begin
            emit        = 1'b0;
            phase_nxt   = PH_HEX_FIRST;
            hex_cnt_nxt = 2'd0;
            hex_acc_nxt = 12'd0;
          end
          default: job = done_job(ST_BAD_ESC);
        endcase
      end

      PH_HEX_FIRST, PH_HEX_SECOND: begin
        if (!hv[4]) begin
          emit = 1'b1;
          job  = done_job(ST_BAD_HEX);
        end else if (hex_cnt_r != 2'd3) begin
          hex_cnt_nxt = hex_cnt_r + 2'd1;
          hex_acc_nxt = {hex_acc_r[7:0], hv[3:0]};
        end else begin
          hex_cnt_nxt = 2'd0;
          hex_acc_nxt = 12'd0;
          if (phase_r == PH_HEX_FIRST) begin
            if (full_val[15:10] == SURR_HIGH_TAG) begin
              high_nxt  = full_val[9:0];
              phase_nxt = PH_WANT_BS;
            end else begin
              emit      = 1'b1;
              job       = utf8_encode({5'd0, full_val});
              phase_nxt = PH_NORMAL;
            end
          end else if (full_val[15:10] != SURR_LOW_TAG) begin
            emit = 1'b1;
            job  = done_job(ST_BAD_SURR);
          end else begin
            emit      = 1'b1;
            job       = utf8_encode({1'b0, high_r, full_val[9:0]} + SUPP_BASE);
            phase_nxt = PH_NORMAL;
          end
        end
      end

      PH_WANT_BS: begin
        if (c == CH_BSLASH) begin
          phase_nxt = PH_WANT_U;
        end else begin
          emit = 1'b1;
          job  = done_job(ST_BAD_SURR);
        end
      end

      PH_WANT_U: begin
        if (c == CH_U) begin
          phase_nxt   = PH_HEX_SECOND;
          hex_cnt_nxt = 2'd0;
          hex_acc_nxt = 12'd0;
        end else begin
          emit = 1'b1;
          job  = done_job(ST_BAD_SURR);
        end
      end

      // Normal phase; unused codes behave the same way.
      default: begin
        phase_nxt = PH_NORMAL;
        if (c == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else begin
          emit = 1'b1;
          if (c == CH_QUOTE)      job = done_job(ST_OK);
          else if (c == CH_NUL)   job = done_job(ST_NO_QUOTE);
          else if (c < CH_SPACE)  job = done_job(ST_BAD_CHAR);
          else                    job = one_byte(c);
        end
      end
    endcase

    // Any done result returns the parser to its reset state.
    if (emit && job.is_done) begin
      phase_nxt   = PH_NORMAL;
      hex_cnt_nxt = 2'd0;
      hex_acc_nxt = 12'd0;
      high_nxt    = 10'd0;
    end
  end

  assign q_push = accept && emit;
  assign q_job  = job;

endmodule

// ===== src/jsu_queue.sv =====
// Short job queue between the front and back ends, built from registers.
// Depends on jsu_pkg.
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output jsu_pkg::job_t head_job
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = slot_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== src/jsu_back.sv =====
// Back end: plays each queued job out as result beats, keeps the saturating
// decoded-length count, and holds the output register. Depends on jsu_pkg, jsu_out_if.
module jsu_back #(
  parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jsu_pkg::job_t q_job,
  output logic          q_pop,
  jsu_out_if.source     out_ch
);
  import jsu_pkg::*;

  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    is_done_r;
  logic [2:0]              status_r;
  logic [OUT_LEN_W-1:0]    out_len_r;
  logic                    last_r;
  logic [1:0]              beat_r;
  logic [LENGTH_WIDTH-1:0] len_r;
  logic [LENGTH_WIDTH-1:0] len_inc;
  logic [LENGTH_WIDTH-1:0] len_shown;
  logic [OUT_LEN_W-1:0]    len_out;
  logic                    adv;
  logic                    last_beat;

  // The output register advances when empty or when its beat is taken.
  assign adv       = !out_valid_r || out_ch.ready;
  assign last_beat = (beat_r == q_job.last_idx);
  assign q_pop     = adv && q_valid && last_beat;
  assign len_inc   = (len_r == '1) ? len_r : len_r + 1'b1;
  assign len_shown = q_job.is_done ? len_r : len_inc;

  // Fit the counter to the 16-bit length field.
  generate
    if (LENGTH_WIDTH >= OUT_LEN_W) begin : g_len_trunc
      assign len_out = len_shown[OUT_LEN_W-1:0];
    end else begin : g_len_ext
      assign len_out = {{(OUT_LEN_W - LENGTH_WIDTH){1'b0}}, len_shown};
    end
  endgenerate

  // Control: output valid, beat index and length count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= 2'd0;
      len_r       <= '0;
    end else if (adv) begin
      out_valid_r <= q_valid;
      if (q_valid) begin
        beat_r <= last_beat ? 2'd0 : beat_r + 2'd1;
        len_r  <= q_job.is_done ? '0 : len_inc;
      end
    end
  end

  // Beat payload.
  always_ff @(posedge clk) begin
    if (adv && q_valid) begin
      out_byte_r <= q_job.is_done ? 8'd0 : q_job.bytes[beat_r];
      is_done_r  <= q_job.is_done;
      status_r   <= q_job.status;
      out_len_r  <= len_out;
      last_r     <= last_beat;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.is_done        = is_done_r;
  assign out_ch.status         = status_r;
  assign out_ch.decoded_length = out_len_r;
  assign out_ch.last           = last_r;

endmodule

// ===== src/json_string_unescape_utf8_core.sv =====
// Top level of the JSON string unescape core: front parser, job queue, back end.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
//   Channel | Direction | Payload                                            | Handshake
//   in_ch   | sink      | in_byte[7:0]                                       | valid/ready
//   out_ch  | source    | out_byte, is_done, status, decoded_length, last    | valid/ready
//
// The front takes one byte per cycle while the queue has room; the back sends
// one beat per cycle while out_ch is ready, so a code point of n UTF-8 bytes goes out as n beats.
// The first beat of an accepted byte is written into the queue and then into the output register.
// Sustained rate is one byte per cycle while out_ch is ready, bounded by the single output beat per cycle.
// Reset is synchronous and active low; it clears parser state, queue and length count.
// A stalled output fills the queue, and then the input ready drops.
module json_string_unescape_utf8_core #(
  parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);
  import jsu_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t head_job;

  // Parser and classifier.
  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // Decoupling queue.
  jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Beat sequencer and output register.
  jsu_back #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
